@@ rtl/hns_pkg.sv @@
// Shared types, constants and helpers of the heightmap normal stream core.
package hns_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int HEIGHT_W   = 9;
  localparam int SLOPE_W    = 9;
  localparam int COORD_W    = 8;
  localparam int CFG_W      = 9;
  localparam int OUT_FIELDS_W = HEIGHT_W + 2 * SLOPE_W + 2 * COORD_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SAMPLE_W-1:0] NEUTRAL_RAW = 8'd127;
  localparam logic [CFG_W-1:0]    SIDE_RESET  = 9'd256;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_DRAIN  = 1'b1
  } cmd_t;

  typedef logic [SAMPLE_W-1:0] raw_t;

  // raw - 127 as a signed height
  function automatic logic signed [HEIGHT_W-1:0] centered(input raw_t raw);
    centered = $signed({1'b0, raw}) - $signed({1'b0, NEUTRAL_RAW});
  endfunction

  // a - b of two raw samples, fits 9 bits signed
  function automatic logic signed [SLOPE_W-1:0] raw_diff(input raw_t a, input raw_t b);
    logic [SAMPLE_W+1:0] d;
    d = {2'b00, a} - {2'b00, b};
    raw_diff = $signed(d[SLOPE_W-1:0]);
  endfunction

endpackage

@@ rtl/hns_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
module hns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 514
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/heightmap_normal_stream_core.sv @@
// Top level: streamed heightmap to centered height and central-difference slopes.
// Usage
//   cfg_valid/cfg_ready/cfg_data write grid_side (samples per row and rows).
//   Values are clamped to [2, MAX_SIDE]; a write restarts the frame. Write only
//   while the stream is idle. cfg_ready is always high.
//   in_* takes one word per point in raster order: tuser = command
//   (sample or drain), tdata = raw height byte.
//   out_* gives one word per grid point: tdata = height, slope_x, slope_y,
//   column, row_index; tlast marks the final point of the frame.
// Timing: point p is loaded into the output register when input word
//   p + grid_side + 1 of the frame is accepted; the first grid_side + 1 words
//   of a frame give nothing. After the last sample, grid_side + 1 drain words
//   flush the final row and sample.
// Throughput: one word per cycle while no held result blocks the input, set by
//   the single-pass stencil between the line-buffer RAM (one write, two
//   prefetched reads per word) and the output register.
// Stall: in_tready = !out_tvalid || out_tready, so a held result blocks input
//   only while it is not taken.
// Reset: grid_side = min(256, MAX_SIDE), frame counters zero; line buffer
//   contents are left as they are (every read used hits a word of the same frame).
module heightmap_normal_stream_core #(
  parameter int MAX_SIDE = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hns_pkg::CFG_W-1:0]        cfg_data,     // [8:0] grid_side
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hns_pkg::SAMPLE_W-1:0]     in_tdata,     // [7:0] sample
  input  logic                             in_tuser,     // [0] command
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hns_pkg::OUT_DATA_W-1:0]   out_tdata,    // [8:0] height, [17:9] slope_x,
                                                         // [26:18] slope_y, [34:27] column,
                                                         // [42:35] row_index, rest zero
  output logic                             out_tlast     // last
);

  import hns_pkg::*;

  localparam int LINE_DEPTH = 2 * MAX_SIDE + 2;
  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int SW  = $clog2(MAX_SIDE + 1);          // holds the side itself
  localparam int NW  = SW + 1;                        // compare width
  localparam int CW  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int TW  = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int KW  = $clog2(MAX_SIDE * MAX_SIDE + MAX_SIDE + 1);
  localparam int SIDE_RST = (256 > MAX_SIDE) ? MAX_SIDE : 256;

  localparam logic [AW:0] DEPTH_EXT = (AW + 1)'(LINE_DEPTH);
  localparam logic [AW:0] WP_LAST   = (AW + 1)'(LINE_DEPTH - 1);

  // ---------------- configuration, with derived frame constants ----------------
  logic [SW-1:0] side_r,   side_cfg;
  logic [TW-1:0] total_r,  total_cfg;
  logic [KW-1:0] last_k_r, last_k_cfg;
  logic [AW:0]   off_b_r,  off_b_cfg;     // 2*side + 1
  logic [2*SW-1:0] side_sq;

  always_comb begin
    if (cfg_data < 9'd2) begin
      side_cfg = SW'(2);
    end else if (32'(cfg_data) > MAX_SIDE) begin
      side_cfg = SW'(MAX_SIDE);
    end else begin
      side_cfg = SW'(cfg_data);
    end
    side_sq    = side_cfg * side_cfg;
    total_cfg  = TW'(side_sq);
    last_k_cfg = KW'(side_sq) + KW'(side_cfg);
    off_b_cfg  = {AW'(side_cfg), 1'b1};
  end

  assign cfg_ready = 1'b1;
  logic cfg_fire;
  assign cfg_fire = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= SW'(SIDE_RST);
      total_r  <= TW'(SIDE_RST * SIDE_RST);
      last_k_r <= KW'(SIDE_RST * SIDE_RST + SIDE_RST);
      off_b_r  <= (AW + 1)'(2 * SIDE_RST + 1);
    end else if (cfg_fire) begin
      side_r   <= side_cfg;
      total_r  <= total_cfg;
      last_k_r <= last_k_cfg;
      off_b_r  <= off_b_cfg;
    end
  end

  // ---------------- frame counters ----------------
  logic [AW-1:0] wp_r,    wp_nxt;
  logic [KW-1:0] items_r, items_nxt;
  logic [CW-1:0] col_r,   col_nxt;
  logic [CW-1:0] row_r,   row_nxt;

  logic in_fire, emit, is_last;
  raw_t raw;

  assign in_tready = !out_tvalid || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // drain words, and anything past the grid, enter as neutral height
  assign raw = (cmd_t'(in_tuser) == CMD_SAMPLE && KW'(total_r) > items_r) ?
               in_tdata : NEUTRAL_RAW;

  assign emit    = items_r > KW'(side_r);
  assign is_last = items_r == last_k_r;

  logic col_end, has_left, has_right, has_prev, has_next;
  assign has_left  = col_r != '0;
  assign has_prev  = row_r != '0;
  assign has_right = (NW'(col_r) + NW'(1)) < NW'(side_r);
  assign has_next  = (NW'(row_r) + NW'(1)) < NW'(side_r);
  assign col_end   = !has_right;

  always_comb begin
    wp_nxt    = wp_r;
    items_nxt = items_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (cfg_fire) begin
      wp_nxt    = '0;
      items_nxt = '0;
      col_nxt   = '0;
      row_nxt   = '0;
    end else if (in_fire) begin
      if (emit && is_last) begin
        wp_nxt    = '0;
        items_nxt = '0;
        col_nxt   = '0;
        row_nxt   = '0;
      end else begin
        items_nxt = items_r + KW'(1);
        wp_nxt    = ((AW + 1)'(wp_r) == WP_LAST) ? '0 : wp_r + AW'(1);
        if (emit) begin
          if (col_end) begin
            col_nxt = '0;
            row_nxt = row_r + CW'(1);
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      items_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      wp_r    <= wp_nxt;
      items_r <= items_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // ---------------- line buffer ----------------
  // Reads for the next word are issued at this accept, so the RAM output
  // already holds sample k-side (port a) and k-2*side-1 (port b) for word k.
  logic [AW:0]   wp_ext, addr_a_ext, addr_b_ext, off_a;
  logic [AW-1:0] raddr_a, raddr_b;
  raw_t          rd_a, rd_b;

  assign wp_ext = (AW + 1)'(wp_nxt);
  assign off_a  = (AW + 1)'(side_r);

  always_comb begin
    addr_a_ext = (wp_ext >= off_a)   ? wp_ext - off_a   : wp_ext + DEPTH_EXT - off_a;
    addr_b_ext = (wp_ext >= off_b_r) ? wp_ext - off_b_r : wp_ext + DEPTH_EXT - off_b_r;
  end

  assign raddr_a = addr_a_ext[AW-1:0];
  assign raddr_b = addr_b_ext[AW-1:0];

  hns_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .we      (in_fire),
    .waddr   (wp_r),
    .wdata   (raw),
    .re      (in_fire),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // taps: k-1 (below), k-side-1 (center), k-side-2 (left)
  raw_t below_r, center_r, left_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      below_r  <= raw;
      center_r <= rd_a;
      left_r   <= center_r;
    end
  end

  // ---------------- stencil and output register ----------------
  raw_t r_left, r_right, r_prev, r_next;
  assign r_left  = has_left  ? left_r  : NEUTRAL_RAW;
  assign r_right = has_right ? rd_a    : NEUTRAL_RAW;
  assign r_prev  = has_prev  ? rd_b    : NEUTRAL_RAW;
  assign r_next  = has_next  ? below_r : NEUTRAL_RAW;

  logic [OUT_FIELDS_W-1:0] fields;
  assign fields = {COORD_W'(row_r), COORD_W'(col_r),
                   raw_diff(r_next, r_prev), raw_diff(r_right, r_left),
                   centered(center_r)};

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data_r <= OUT_DATA_W'(fields);
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/hns_checker.sv @@
// Port-level checker for the heightmap normal stream core, with its bind.
module hns_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hns_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                            out_tlast
);

  import hns_pkg::*;

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // input may only stall while a result is waiting and not taken
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled without a pending result");

  // every new result word is caused by an accepted input word
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid && !out_tready) |-> $past(in_tvalid && in_tready))
    else $error("result word without an accepted input word");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind heightmap_normal_stream_core hns_checker u_hns_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ tb/heightmap_normal_stream_core_tb.sv @@
// Self-checking testbench for the heightmap normal stream core.
`timescale 1ns / 1ps

module heightmap_normal_stream_core_tb;
  import hns_pkg::*;

  // Ring depth of the testbench line store; every read reaches at most
  // 2*side+1 words back, so any depth above that behaves the same.
  localparam int LINE_DEPTH = 2 * 256 + 2;
  localparam int MAX_IDLE   = 5;

  typedef struct {
    cmd_t cmd;
    raw_t smp;
  } height_word_t;

  typedef struct {
    logic signed [HEIGHT_W-1:0] height;
    logic signed [SLOPE_W-1:0]  slope_x;
    logic signed [SLOPE_W-1:0]  slope_y;
    logic [COORD_W-1:0]         column;
    logic [COORD_W-1:0]         row_index;
    logic                       last;
  } normal_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [SAMPLE_W-1:0]    in_tdata = '0;      // [7:0] sample
  logic                   in_tuser = 1'b0;    // [0] command
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;          // [8:0] height, [17:9] slope_x,
                                              // [26:18] slope_y, [34:27] column,
                                              // [42:35] row_index, rest zero
  logic                   out_tlast;          // last

  // handshake flags, set at the rising edge and read by the drivers at the falling edge
  logic in_word_taken  = 1'b0;
  logic out_word_taken = 1'b0;
  logic cfg_word_taken = 1'b0;

  height_word_t height_words[$];      // words still to be driven
  normal_t      pending_normals[$];   // predicted results not yet seen
  int           error_count = 0;
  int unsigned  in_idle_max = MAX_IDLE;
  int unsigned  out_idle_max = MAX_IDLE;
  int unsigned  in_wait = 0;
  int unsigned  out_stall = 0;

  // predictor state
  raw_t         line_mem [0:LINE_DEPTH-1];
  logic [CFG_W-1:0] side_reg = SIDE_RESET;
  int unsigned  wr_ptr = 0;
  int unsigned  frame_words = 0;
  int unsigned  pt_col = 0;
  int unsigned  pt_row = 0;

  heightmap_normal_stream_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // register value clamped to the supported side range
  function automatic int unsigned side_used(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return 32'(v);
  endfunction

  // centered height of the word stored 'back' words before the current one
  function automatic int height_back(input int unsigned back);
    int unsigned idx;
    idx = (wr_ptr + LINE_DEPTH - (back % LINE_DEPTH)) % LINE_DEPTH;
    return int'(line_mem[idx]) - int'(NEUTRAL_RAW);
  endfunction

  function automatic void restart_frame();
    wr_ptr = 0;
    frame_words = 0;
    pt_col = 0;
    pt_row = 0;
  endfunction

  // Point p of the frame comes out with word p + side + 1. Neighbors off the
  // grid read as height zero; drain words inside the grid count as level
  // samples, samples after the grid count as drain words.
  task automatic predict_normal(input cmd_t cmd, input raw_t smp);
    int unsigned s, total, k, c, r;
    int h_c, h_l, h_r, h_up, h_dn;
    normal_t e;
    s = side_used(side_reg);
    total = s * s;
    k = frame_words;
    line_mem[wr_ptr] = (cmd == CMD_SAMPLE && k < total) ? smp : NEUTRAL_RAW;
    if (k < s + 1) begin
      frame_words = k + 1;
      wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      return;
    end
    c = pt_col;
    r = pt_row;
    h_c  = height_back(s + 1);
    h_l  = (c > 0) ? height_back(s + 2) : 0;
    h_r  = (c + 1 < s) ? height_back(s) : 0;
    h_up = (r > 0) ? height_back(2 * s + 1) : 0;
    h_dn = (r + 1 < s) ? height_back(1) : 0;
    e.height    = HEIGHT_W'(h_c);
    e.slope_x   = SLOPE_W'(h_r - h_l);
    e.slope_y   = SLOPE_W'(h_dn - h_up);
    e.column    = COORD_W'(c);
    e.row_index = COORD_W'(r);
    e.last      = (k - s - 1 == total - 1);
    pending_normals.push_back(e);
    if (e.last) begin
      restart_frame();
    end else begin
      frame_words = k + 1;
      wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      if (c + 1 >= s) begin
        pt_col = 0;
        pt_row = r + 1;
      end else begin
        pt_col = c + 1;
      end
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Rising edge: handshakes, prediction and result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    normal_t e;
    in_word_taken  <= rst_n && in_tvalid && in_tready;
    out_word_taken <= rst_n && out_tvalid && out_tready;
    cfg_word_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        side_reg = cfg_data;   // a side write restarts the frame, line store kept
        restart_frame();
      end
      if (in_tvalid && in_tready)
        predict_normal(cmd_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) begin
        if (pending_normals.size() == 0) begin
          $error("result word with nothing expected: tdata %h tlast %b", out_tdata, out_tlast);
          error_count++;
        end else begin
          e = pending_normals.pop_front();
          check_field("height", int'(e.height), int'($signed(out_tdata[8:0])));
          check_field("slope_x", int'(e.slope_x), int'($signed(out_tdata[17:9])));
          check_field("slope_y", int'(e.slope_y), int'($signed(out_tdata[26:18])));
          check_field("column", int'(e.column), int'(out_tdata[34:27]));
          check_field("row_index", int'(e.row_index), int'(out_tdata[42:35]));
          check_field("tdata_pad", 0, int'(out_tdata[OUT_DATA_W-1:43]));
          check_field("last", int'(e.last), int'(out_tlast));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Falling edge: input driver and output back-pressure
  // ---------------------------------------------------------------------------

  // Input driver: holds a word until taken, then waits a random gap before the next.
  always @(negedge clk) begin
    height_word_t w;
    if (rst_n && !(in_tvalid && !in_word_taken)) begin
      if (in_tvalid && in_word_taken)
        in_wait = $urandom_range(0, in_idle_max);
      if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (height_words.size() != 0) begin
        w = height_words.pop_front();
        in_tuser  <= w.cmd;
        in_tdata  <= w.smp;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: a random stall before each result, then ready until taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_word_taken)
        out_stall = $urandom_range(0, out_idle_max);
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_word(input cmd_t cmd, input raw_t smp);
    height_word_t w;
    w.cmd = cmd;
    w.smp = smp;
    height_words.push_back(w);
  endfunction

  // random raw height, biased toward the extremes and the level value
  function automatic raw_t pick_raw();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return NEUTRAL_RAW;
      default: return raw_t'($urandom);
    endcase
  endfunction

  // n words of back-to-back frames of side s: grid samples with a few drain
  // words mixed in, then the flush run with a few stray samples.
  function automatic void add_frames(input int unsigned s, input int unsigned n);
    int unsigned frame_len, pos;
    frame_len = s * s + s + 1;
    for (int unsigned i = 0; i < n; i++) begin
      pos = i % frame_len;
      if (pos < s * s)
        add_word(($urandom_range(0, 15) == 0) ? CMD_DRAIN : CMD_SAMPLE, pick_raw());
      else
        add_word(($urandom_range(0, 3) == 0) ? CMD_SAMPLE : CMD_DRAIN, pick_raw());
    end
  endfunction

  // all words taken and all results seen, checked at the rising edge where the
  // driver outputs have settled, plus a few cycles for words without a result
  task automatic wait_drained();
    do @(posedge clk);
    while (height_words.size() != 0 || in_tvalid || out_tvalid ||
           pending_normals.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_side(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_word_taken);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] side_val;
    int unsigned s, n, frame_len, words_queued;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Reset side (256): a few words, too early for any result.
    add_word(CMD_SAMPLE, 8'h00);
    add_word(CMD_SAMPLE, 8'hff);
    add_word(CMD_DRAIN, 8'h5a);
    add_word(CMD_SAMPLE, 8'h55);
    add_word(CMD_SAMPLE, 8'haa);
    wait_drained();

    // Side 3, written mid-frame. Rows 0 and 2 give slope_x of +255 and -255,
    // columns 0 and 2 give slope_y of +255 and -255. One grid point is a drain
    // word (level sample) and one flush word is a sample (ignored).
    write_side(9'd3);
    add_word(CMD_SAMPLE, 8'd0);
    add_word(CMD_SAMPLE, 8'd128);
    add_word(CMD_SAMPLE, 8'd255);
    add_word(CMD_DRAIN, 8'hff);
    add_word(CMD_SAMPLE, 8'd200);
    add_word(CMD_SAMPLE, 8'd33);
    add_word(CMD_SAMPLE, 8'd255);
    add_word(CMD_SAMPLE, 8'd64);
    add_word(CMD_SAMPLE, 8'd0);
    add_word(CMD_DRAIN, 8'h00);
    add_word(CMD_SAMPLE, 8'hc3);
    add_word(CMD_DRAIN, 8'h00);
    add_word(CMD_DRAIN, 8'h00);
    wait_drained();

    // Side 0 clamps to 2: one full frame.
    write_side(9'd0);
    add_word(CMD_SAMPLE, 8'd255);
    add_word(CMD_SAMPLE, 8'd0);
    add_word(CMD_SAMPLE, 8'd0);
    add_word(CMD_SAMPLE, 8'd255);
    add_word(CMD_DRAIN, 8'h00);
    add_word(CMD_DRAIN, 8'hff);
    add_word(CMD_DRAIN, 8'h00);
    wait_drained();

    // Largest setting (511 clamps to 256): partial frame reaching into row 1.
    words_queued = 0;
    write_side(9'd511);
    add_frames(256, 530);
    words_queued += 530;
    wait_drained();

    // Random phases: mostly small sides with whole frames, some broken frames,
    // occasional large sides with short partial frames.
    while (words_queued < 975) begin
      case ($urandom_range(0, 15))
        0:       side_val = CFG_W'($urandom_range(0, 1));
        1:       side_val = ($urandom_range(0, 1) != 0) ? 9'd256 : CFG_W'($urandom_range(257, 511));
        2, 3:    side_val = CFG_W'($urandom_range(9, 20));
        default: side_val = CFG_W'($urandom_range(2, 8));
      endcase
      s = side_used(side_val);
      frame_len = s * s + s + 1;
      if (s > 20) begin
        n = $urandom_range(50, 200);
      end else begin
        case ($urandom_range(0, 3))
          0:       n = $urandom_range(1, frame_len - 1);
          1:       n = 2 * frame_len;
          default: n = frame_len;
        endcase
      end
      if (n > 975 - words_queued)
        n = 975 - words_queued;
      in_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      write_side(side_val);
      add_frames(s, n);
      words_queued += n;
      wait_drained();
    end

    repeat (16) @(negedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
